/* rtl/vafr_pkg.sv */
// ----------------------------------------------------------------------------
// vafr_pkg
// Shared types, offsets, register indexes and helpers for the video adapter
// register file.
// ----------------------------------------------------------------------------
package vafr_pkg;

	// Text page geometry
	localparam int TEXT_COLUMNS = 80;
	localparam int TEXT_CELLS   = 2000;

	// Field widths
	localparam int OFS_W  = 4;
	localparam int DATA_W = 8;
	localparam int MODE_W = 2;
	localparam int CLR_W  = 4;
	localparam int ADDR_W = 16;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int CNT_W  = 6;
	localparam int NREGS  = 16;
	localparam int REG_W  = $clog2(NREGS);

	// Cell division: reciprocal estimate, at most one below the true quotient
	localparam int CELL_W      = $clog2(TEXT_CELLS);
	localparam int RECIP_SHIFT = CELL_W + 6;
	localparam int RECIP_MUL   = (1 << RECIP_SHIFT) / TEXT_COLUMNS;
	localparam int RECIP_W     = $clog2(RECIP_MUL + 1);
	localparam int PROD_W      = CELL_W + RECIP_W;
	localparam int QUO_W       = PROD_W - RECIP_SHIFT;

	// Access kinds
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Window offsets
	localparam logic [OFS_W-1:0] OFS_INDEX   = 4'd0;
	localparam logic [OFS_W-1:0] OFS_DATA    = 4'd1;
	localparam logic [OFS_W-1:0] OFS_MODE    = 4'd4;
	localparam logic [OFS_W-1:0] OFS_PALETTE = 4'd5;
	localparam logic [OFS_W-1:0] OFS_STATUS  = 4'd6;

	// Controller register indexes
	localparam logic [REG_W-1:0] REG_CUR_START  = 4'd10;
	localparam logic [REG_W-1:0] REG_CUR_END    = 4'd11;
	localparam logic [REG_W-1:0] REG_START_HI   = 4'd12;
	localparam logic [REG_W-1:0] REG_START_LO   = 4'd13;
	localparam logic [REG_W-1:0] REG_CUR_ADR_HI = 4'd14;
	localparam logic [REG_W-1:0] REG_CUR_ADR_LO = 4'd15;

	// Video modes
	localparam logic [MODE_W-1:0] MODE_TEXT  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FOUR  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HIRES = 2'd2;

	// Mode and palette control bits
	localparam int MODE_GFX_BIT = 1;
	localparam int MODE_HI_BIT  = 4;
	localparam int PAL_SET_BIT  = 5;

	localparam logic [DATA_W-1:0] UNMAPPED = 8'hff;

	typedef struct packed {
		logic              operation;
		logic [OFS_W-1:0]  offset;
		logic [DATA_W-1:0] write_data;
	} req_t;

	typedef struct packed {
		logic [MODE_W-1:0] video_mode;
		logic              palette_select;
		logic [CLR_W-1:0]  colour_zero;
		logic [CLR_W-1:0]  colour_one;
		logic [CLR_W-1:0]  colour_two;
		logic [CLR_W-1:0]  colour_three;
		logic [DATA_W-1:0] cursor_top;
		logic [DATA_W-1:0] cursor_bottom;
		logic [ADDR_W-1:0] page_offset;
		logic [COL_W-1:0]  cursor_column;
		logic [ROW_W-1:0]  cursor_row;
	} view_t;

	typedef struct packed {
		logic             in_page;
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
	} place_t;

	// Scale a cursor line (0..7) to display lines; lines above 7 give 0
	function automatic logic [DATA_W-1:0] scale_line(input logic [DATA_W-1:0] y);
		logic [2:0] v;
		v = (y <= 8'd7) ? 3'(3'd7 - y[2:0]) : 3'd0;
		return {v, v, v[2:1]};
	endfunction

	// Fixed palette entry 1..3 for a palette set
	function automatic logic [CLR_W-1:0] fixed_colour(input logic pal, input logic [1:0] ent);
		logic [CLR_W-1:0] c;
		case (ent)
			2'd1:    c = pal ? 4'd2  : 4'd3;
			2'd2:    c = pal ? 4'd4  : 4'd5;
			2'd3:    c = pal ? 4'd14 : 4'd15;
			default: c = 4'd0;
		endcase
		return c;
	endfunction

endpackage

/* rtl/vafr_req_if.sv */
// ----------------------------------------------------------------------------
// vafr_req_if
// Request channel: one byte access to the adapter window per transfer.
// ----------------------------------------------------------------------------
interface vafr_req_if import vafr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              operation;
	logic [OFS_W-1:0]  offset;
	logic [DATA_W-1:0] write_data;

	modport source(output valid, output operation, output offset, output write_data,
		input ready);
	modport sink(input valid, input operation, input offset, input write_data,
		output ready);
endinterface

/* rtl/vafr_rsp_if.sv */
// ----------------------------------------------------------------------------
// vafr_rsp_if
// Result channel: read byte and display state after each access.
// ----------------------------------------------------------------------------
interface vafr_rsp_if import vafr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;
	logic [MODE_W-1:0] video_mode;
	logic              palette_select;
	logic [CLR_W-1:0]  colour_zero;
	logic [CLR_W-1:0]  colour_one;
	logic [CLR_W-1:0]  colour_two;
	logic [CLR_W-1:0]  colour_three;
	logic [DATA_W-1:0] cursor_top;
	logic [DATA_W-1:0] cursor_bottom;
	logic [ADDR_W-1:0] page_offset;
	logic [COL_W-1:0]  cursor_column;
	logic [ROW_W-1:0]  cursor_row;

	modport source(output valid, output read_data, output video_mode,
		output palette_select, output colour_zero, output colour_one, output colour_two,
		output colour_three, output cursor_top, output cursor_bottom, output page_offset,
		output cursor_column, output cursor_row, input ready);
	modport sink(input valid, input read_data, input video_mode,
		input palette_select, input colour_zero, input colour_one, input colour_two,
		input colour_three, input cursor_top, input cursor_bottom, input page_offset,
		input cursor_column, input cursor_row, output ready);
endinterface

/* rtl/vafr_cursor.sv */
// ----------------------------------------------------------------------------
// vafr_cursor
// Map a cursor address to a text cell (column, row) relative to the display
// start, and flag whether it lies on the visible page.
// ----------------------------------------------------------------------------
module vafr_cursor import vafr_pkg::*; (
	input  logic [ADDR_W-1:0] cursor_address,
	input  logic [ADDR_W-1:0] display_start,
	output place_t            place
);

	logic [ADDR_W:0]     diff;
	logic [CELL_W-1:0]   rel;
	logic [PROD_W-1:0]   prod;
	logic [QUO_W-1:0]    quo_est;
	logic [CELL_W-1:0]   rem_est;
	logic                fix;
	logic [CELL_W-1:0]   col;
	logic [QUO_W-1:0]    row;

	// Offset from the display start; the top bit is the borrow
	assign diff = {1'b0, cursor_address} - {1'b0, display_start};
	assign rel  = diff[CELL_W-1:0];

	assign place.in_page = !diff[ADDR_W] && (diff[ADDR_W-1:0] < ADDR_W'(TEXT_CELLS));

	// Divide by the row length: reciprocal estimate, then one correction step
	assign prod    = PROD_W'(rel) * PROD_W'(RECIP_MUL);
	assign quo_est = prod[PROD_W-1:RECIP_SHIFT];
	assign rem_est = rel - CELL_W'(quo_est * TEXT_COLUMNS);
	assign fix     = rem_est >= CELL_W'(TEXT_COLUMNS);
	assign col     = fix ? CELL_W'(rem_est - CELL_W'(TEXT_COLUMNS)) : rem_est;
	assign row     = QUO_W'(quo_est + QUO_W'(fix));

	assign place.column = COL_W'(col);
	assign place.row    = ROW_W'(row);

endmodule

/* rtl/vafr_regs.sv */
// ----------------------------------------------------------------------------
// vafr_regs
// Register window state: controller index and bank, mode, palette, status
// byte with its read counter, and the derived cursor shape, page offset and
// cursor cell. Applies one access per step and returns the read byte.
// ----------------------------------------------------------------------------
module vafr_regs import vafr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  req_t              item,
	output logic [DATA_W-1:0] read_data,
	output view_t             view
);

	logic [DATA_W-1:0] index_q;
	logic [DATA_W-1:0] bank_q [NREGS];
	logic [DATA_W-1:0] status_q;
	logic [CNT_W-1:0]  count_q;
	logic [MODE_W-1:0] mode_q;
	logic              palette_q;
	logic [CLR_W-1:0]  colour0_q;
	logic [ADDR_W-1:0] start_q;
	logic [DATA_W-1:0] top_q;
	logic [DATA_W-1:0] bottom_q;
	logic [COL_W-1:0]  column_q;
	logic [ROW_W-1:0]  row_q;

	logic              wr;
	logic              index_ok;
	logic [REG_W-1:0]  sel;
	logic              crtc_wr;
	logic              status_rd;
	logic [CNT_W:0]    count_inc;
	logic [DATA_W-1:0] status_next;
	logic [CNT_W-1:0]  count_next;
	logic [DATA_W-1:0] line_a;
	logic [DATA_W-1:0] line_b;
	logic              shape_upd;
	logic [DATA_W-1:0] shape_top;
	logic [DATA_W-1:0] shape_bottom;
	logic              start_upd;
	logic [ADDR_W-1:0] start_next;
	logic              place_upd;
	logic [MODE_W-1:0] mode_next;
	place_t            place;

	assign wr        = item.operation == OP_WRITE;
	assign index_ok  = index_q[DATA_W-1:REG_W] == '0;
	assign sel       = index_q[REG_W-1:0];
	assign crtc_wr   = wr && item.offset == OFS_DATA && index_ok;
	assign status_rd = !wr && item.offset == OFS_STATUS;

	// Status read counter: toggle bit 0 every eighth read, bit 3 on wrap
	always_comb begin
		count_inc   = {1'b0, count_q} + 1'b1;
		status_next = status_q;
		count_next  = count_inc[CNT_W-1:0];
		if (count_inc[2:0] == 3'd0) begin
			status_next[0] = ~status_q[0];
		end
		if (count_inc[CNT_W]) begin
			count_next     = '0;
			status_next[3] = ~status_q[3];
		end
	end

	// Cursor shape from the start and end line registers as written
	always_comb begin
		line_a = (sel == REG_CUR_END) ? item.write_data : bank_q[REG_CUR_END];
		line_b = (sel == REG_CUR_START) ? item.write_data : bank_q[REG_CUR_START];
		if (line_a < line_b) begin
			line_a = 8'd0;
			line_b = 8'd7;
		end
		shape_top    = scale_line(line_a);
		shape_bottom = scale_line(line_b);
	end

	assign shape_upd = crtc_wr && mode_q == MODE_TEXT
		&& (sel == REG_CUR_START || sel == REG_CUR_END);

	// Display start from the two start registers as written
	assign start_next = {(sel == REG_START_HI) ? item.write_data : bank_q[REG_START_HI],
		(sel == REG_START_LO) ? item.write_data : bank_q[REG_START_LO]};
	assign start_upd  = crtc_wr && (sel == REG_START_HI || sel == REG_START_LO);

	// Cursor cell, taken on a write of the low address byte
	vafr_cursor u_cursor (
		.cursor_address ({bank_q[REG_CUR_ADR_HI], item.write_data}),
		.display_start  (start_q),
		.place          (place)
	);

	assign place_upd = crtc_wr && sel == REG_CUR_ADR_LO && mode_q == MODE_TEXT
		&& place.in_page;

	// Decode the mode byte
	always_comb begin
		if (!item.write_data[MODE_GFX_BIT]) begin
			mode_next = MODE_TEXT;
		end else if (!item.write_data[MODE_HI_BIT]) begin
			mode_next = MODE_FOUR;
		end else begin
			mode_next = MODE_HIRES;
		end
	end

	// Read data for this access
	always_comb begin
		read_data = '0;
		if (!wr) begin
			case (item.offset)
				OFS_INDEX:  read_data = index_q;
				OFS_DATA:   read_data = index_ok ? bank_q[sel] : UNMAPPED;
				OFS_STATUS: read_data = status_next;
				default:    read_data = UNMAPPED;
			endcase
		end
	end

	// Controller bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NREGS; i++) begin
				bank_q[i] <= '0;
			end
		end else if (step && crtc_wr) begin
			bank_q[sel] <= item.write_data;
		end
	end

	// Window registers and derived display state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q   <= '0;
			status_q  <= '0;
			count_q   <= '0;
			mode_q    <= MODE_TEXT;
			palette_q <= 1'b0;
			colour0_q <= '0;
			start_q   <= '0;
			top_q     <= '0;
			bottom_q  <= '0;
			column_q  <= '0;
			row_q     <= '0;
		end else if (step) begin
			if (wr) begin
				case (item.offset)
					OFS_INDEX: begin
						index_q <= item.write_data;
					end
					OFS_MODE: begin
						mode_q <= mode_next;
					end
					OFS_PALETTE: begin
						palette_q <= ~item.write_data[PAL_SET_BIT];
						colour0_q <= item.write_data[CLR_W-1:0];
					end
					OFS_STATUS: begin
						status_q <= item.write_data;
					end
					default: begin
					end
				endcase
			end
			if (status_rd) begin
				status_q <= status_next;
				count_q  <= count_next;
			end
			if (shape_upd) begin
				top_q    <= shape_top;
				bottom_q <= shape_bottom;
			end
			if (start_upd) begin
				start_q <= start_next;
			end
			if (place_upd) begin
				column_q <= place.column;
				row_q    <= place.row;
			end
		end
	end

	assign view.video_mode     = mode_q;
	assign view.palette_select = palette_q;
	assign view.colour_zero    = colour0_q;
	assign view.colour_one     = fixed_colour(palette_q, 2'd1);
	assign view.colour_two     = fixed_colour(palette_q, 2'd2);
	assign view.colour_three   = fixed_colour(palette_q, 2'd3);
	assign view.cursor_top     = top_q;
	assign view.cursor_bottom  = bottom_q;
	assign view.page_offset    = start_q;
	assign view.cursor_column  = column_q;
	assign view.cursor_row     = row_q;

endmodule

/* rtl/video_adapter_register_file.sv */
// ----------------------------------------------------------------------------
// video_adapter_register_file
// Byte register window of a text/graphics video adapter with its CRT
// controller, cursor shape, page offset and cursor cell.
// ----------------------------------------------------------------------------
// Each access passes an input register and then a result register, which holds
// its result until it is taken; one access is taken every cycle while results
// are collected. The cursor cell division by the row
// length (one reciprocal multiply and a correction) sits in the single logic
// stage between the two registers. The display fields of a result show the
// state left by that access and stay put until the result is taken.
module video_adapter_register_file import vafr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	vafr_req_if.sink  req,
	vafr_rsp_if.source rsp
);

	req_t              item_s1;
	logic              vld_s1;
	logic              rsp_vld_q;
	logic [DATA_W-1:0] read_data_q;
	logic              advance;
	logic [DATA_W-1:0] read_data;
	view_t             view;

	// Move the held access on when the result register is free or being taken
	assign advance   = vld_s1 && (!rsp_vld_q || rsp.ready);
	assign req.ready = !vld_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= '{operation: req.operation, offset: req.offset,
				write_data: req.write_data};
		end
	end

	vafr_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.read_data (read_data),
		.view      (view)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (advance) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= read_data;
		end
	end

	assign rsp.valid          = rsp_vld_q;
	assign rsp.read_data      = read_data_q;
	assign rsp.video_mode     = view.video_mode;
	assign rsp.palette_select = view.palette_select;
	assign rsp.colour_zero    = view.colour_zero;
	assign rsp.colour_one     = view.colour_one;
	assign rsp.colour_two     = view.colour_two;
	assign rsp.colour_three   = view.colour_three;
	assign rsp.cursor_top     = view.cursor_top;
	assign rsp.cursor_bottom  = view.cursor_bottom;
	assign rsp.page_offset    = view.page_offset;
	assign rsp.cursor_column  = view.cursor_column;
	assign rsp.cursor_row     = view.cursor_row;

	// Hold the queued access while the result waits
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && rsp_vld_q && !rsp.ready |=> vld_s1 && $stable(item_s1))
	else $error("queued access changed while the result was stalled");

	// Every processed access leaves a result behind
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_vld_q)
	else $error("processed access produced no result");

	// Display state frozen while a result waits
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_q && !rsp.ready |=> $stable(view) && $stable(read_data_q))
	else $error("result fields changed while stalled");

endmodule
